// ===== sv/cpsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsd_pkg
// Types and constants shared by the point to capped cylinder distance core.
// ----------------------------------------------------------------------------
package cpsd_pkg;

	localparam int CoordW  = 32;
	localparam int AxisW   = 18;
	localparam int LenW    = 31;
	localparam int DistW   = 48;
	localparam int RegAddrW = 5;

	typedef enum logic [2:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_CENTER_Z    = 3'd2,
		REG_AXIS_X      = 3'd3,
		REG_AXIS_Y      = 3'd4,
		REG_AXIS_Z      = 3'd5,
		REG_CYL_RADIUS  = 3'd6,
		REG_HALF_LENGTH = 3'd7
	} reg_idx_t;

	localparam logic signed [AxisW-1:0] AxisZReset = 18'sd65536;

	typedef struct packed {
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
		logic signed [CoordW-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic [DistW-1:0] sqr_distance;
		logic             saturated;
	} result_t;

endpackage

// ===== sv/point_cylinder_sqr_distance_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_cylinder_sqr_distance_core
// Squared distance from a 3D point to the surface of a capped cylinder.
// ----------------------------------------------------------------------------
// One point transaction is taken in every clock cycle; busy is never raised.
// Each result appears on result with result_valid for one cycle, in the
// order the points were accepted. The bit-serial square root spends one
// pipeline stage per root bit (41); the projection, square and rounding
// stages sit around it. The cylinder registers must only be written while
// no transaction is in flight.
module point_cylinder_sqr_distance_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  cpsd_pkg::point_t                       point,
	output logic                                   result_valid,
	output cpsd_pkg::result_t                      result,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [cpsd_pkg::RegAddrW-1:0]          paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);

	localparam int SqSteps = 41;
	localparam int Latency = 52;

	logic signed [31:0] center_x_q, center_y_q, center_z_q;
	logic signed [17:0] axis_x_q, axis_y_q, axis_z_q;
	logic [30:0]        cyl_radius_q, half_length_q;
	logic [61:0]        r_sq_q;
	logic               wr_en;
	cpsd_pkg::reg_idx_t wr_idx;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite;
	assign wr_idx = cpsd_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			center_z_q    <= '0;
			axis_x_q      <= '0;
			axis_y_q      <= '0;
			axis_z_q      <= cpsd_pkg::AxisZReset;
			cyl_radius_q  <= '0;
			half_length_q <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				cpsd_pkg::REG_CENTER_X:    center_x_q    <= pwdata;
				cpsd_pkg::REG_CENTER_Y:    center_y_q    <= pwdata;
				cpsd_pkg::REG_CENTER_Z:    center_z_q    <= pwdata;
				cpsd_pkg::REG_AXIS_X:      axis_x_q      <= pwdata[17:0];
				cpsd_pkg::REG_AXIS_Y:      axis_y_q      <= pwdata[17:0];
				cpsd_pkg::REG_AXIS_Z:      axis_z_q      <= pwdata[17:0];
				cpsd_pkg::REG_CYL_RADIUS:  cyl_radius_q  <= pwdata[30:0];
				cpsd_pkg::REG_HALF_LENGTH: half_length_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		r_sq_q <= cyl_radius_q * cyl_radius_q;
	end

	always_comb begin
		case (wr_idx)
			cpsd_pkg::REG_CENTER_X:    prdata = center_x_q;
			cpsd_pkg::REG_CENTER_Y:    prdata = center_y_q;
			cpsd_pkg::REG_CENTER_Z:    prdata = center_z_q;
			cpsd_pkg::REG_AXIS_X:      prdata = 32'(axis_x_q);
			cpsd_pkg::REG_AXIS_Y:      prdata = 32'(axis_y_q);
			cpsd_pkg::REG_AXIS_Z:      prdata = 32'(axis_z_q);
			cpsd_pkg::REG_CYL_RADIUS:  prdata = {1'b0, cyl_radius_q};
			cpsd_pkg::REG_HALF_LENGTH: prdata = {1'b0, half_length_q};
			default:                   prdata = '0;
		endcase
	end

	// Stage 1: position relative to the center.
	logic               v_s1;
	logic signed [32:0] rel_x_s1, rel_y_s1, rel_z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		rel_x_s1 <= 33'(point.point_x) - 33'(center_x_q);
		rel_y_s1 <= 33'(point.point_y) - 33'(center_y_q);
		rel_z_s1 <= 33'(point.point_z) - 33'(center_z_q);
	end

	// Stage 2: dot product terms.
	logic               v_s2;
	logic signed [32:0] rel_x_s2, rel_y_s2, rel_z_s2;
	logic signed [50:0] dp_x_s2, dp_y_s2, dp_z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		rel_x_s2 <= rel_x_s1;
		rel_y_s2 <= rel_y_s1;
		rel_z_s2 <= rel_z_s1;
		dp_x_s2  <= 51'(rel_x_s1) * 51'(axis_x_q);
		dp_y_s2  <= 51'(rel_y_s1) * 51'(axis_y_q);
		dp_z_s2  <= 51'(rel_z_s1) * 51'(axis_z_q);
	end

	// Stage 3: rounded axial coordinate.
	logic               v_s3;
	logic signed [32:0] rel_x_s3, rel_y_s3, rel_z_s3;
	logic signed [36:0] proj_s3;
	logic signed [52:0] dsum;

	assign dsum = 53'(dp_x_s2) + 53'(dp_y_s2) + 53'(dp_z_s2) + 53'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		rel_x_s3 <= rel_x_s2;
		rel_y_s3 <= rel_y_s2;
		rel_z_s3 <= rel_z_s2;
		proj_s3  <= dsum[52:16];
	end

	// Stage 4: projection back onto the axis.
	logic               v_s4;
	logic signed [32:0] rel_x_s4, rel_y_s4, rel_z_s4;
	logic signed [36:0] proj_s4;
	logic signed [54:0] qp_x_s4, qp_y_s4, qp_z_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		rel_x_s4 <= rel_x_s3;
		rel_y_s4 <= rel_y_s3;
		rel_z_s4 <= rel_z_s3;
		proj_s4  <= proj_s3;
		qp_x_s4  <= 55'(axis_x_q) * 55'(proj_s3);
		qp_y_s4  <= 55'(axis_y_q) * 55'(proj_s3);
		qp_z_s4  <= 55'(axis_z_q) * 55'(proj_s3);
	end

	// Stage 5: radial offset magnitudes and the axial overshoot.
	logic               v_s5;
	logic [39:0]        m_x_s5, m_y_s5, m_z_s5;
	logic [36:0]        a_s5;
	logic               side_s5;
	logic signed [54:0] qr_x, qr_y, qr_z;
	logic signed [39:0] d_x, d_y, d_z;
	logic [36:0]        ap;

	assign qr_x = qp_x_s4 + 55'sd32768;
	assign qr_y = qp_y_s4 + 55'sd32768;
	assign qr_z = qp_z_s4 + 55'sd32768;
	assign d_x  = 40'(rel_x_s4) - 40'($signed(qr_x[54:16]));
	assign d_y  = 40'(rel_y_s4) - 40'($signed(qr_y[54:16]));
	assign d_z  = 40'(rel_z_s4) - 40'($signed(qr_z[54:16]));
	assign ap   = proj_s4[36] ? 37'(-proj_s4) : 37'(proj_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		m_x_s5  <= d_x[39] ? 40'(-d_x) : 40'(d_x);
		m_y_s5  <= d_y[39] ? 40'(-d_y) : 40'(d_y);
		m_z_s5  <= d_z[39] ? 40'(-d_z) : 40'(d_z);
		side_s5 <= ap <= 37'(half_length_q);
		a_s5    <= (ap <= 37'(half_length_q)) ? '0 : ap - 37'(half_length_q);
	end

	// Stage 6: partial products of the squared offsets.
	logic        v_s6;
	logic [39:0] hh_x_s6, hl_x_s6, ll_x_s6;
	logic [39:0] hh_y_s6, hl_y_s6, ll_y_s6;
	logic [39:0] hh_z_s6, hl_z_s6, ll_z_s6;
	logic [36:0] a_s6;
	logic        side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		hh_x_s6 <= m_x_s5[39:20] * m_x_s5[39:20];
		hl_x_s6 <= m_x_s5[39:20] * m_x_s5[19:0];
		ll_x_s6 <= m_x_s5[19:0] * m_x_s5[19:0];
		hh_y_s6 <= m_y_s5[39:20] * m_y_s5[39:20];
		hl_y_s6 <= m_y_s5[39:20] * m_y_s5[19:0];
		ll_y_s6 <= m_y_s5[19:0] * m_y_s5[19:0];
		hh_z_s6 <= m_z_s5[39:20] * m_z_s5[39:20];
		hl_z_s6 <= m_z_s5[39:20] * m_z_s5[19:0];
		ll_z_s6 <= m_z_s5[19:0] * m_z_s5[19:0];
		a_s6    <= a_s5;
		side_s6 <= side_s5;
	end

	// Stage 7: squared radial distance.
	logic        v_s7;
	logic [81:0] s_s7;
	logic [36:0] a_s7;
	logic        side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else         v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		s_s7 <= (82'(hh_x_s6) << 40) + (82'(hl_x_s6) << 21) + 82'(ll_x_s6)
		      + (82'(hh_y_s6) << 40) + (82'(hl_y_s6) << 21) + 82'(ll_y_s6)
		      + (82'(hh_z_s6) << 40) + (82'(hl_z_s6) << 21) + 82'(ll_z_s6);
		a_s7    <= a_s6;
		side_s7 <= side_s6;
	end

	// Square root, one root bit per stage, remainder kept as S - root^2.
	logic        sq_v_s      [0:SqSteps];
	logic [81:0] sq_rem_s    [0:SqSteps];
	logic [40:0] sq_root_s   [0:SqSteps];
	logic [36:0] sq_a_s      [0:SqSteps];
	logic        sq_side_s   [0:SqSteps];
	logic        sq_beyond_s [0:SqSteps];

	assign sq_v_s[0]      = v_s7;
	assign sq_rem_s[0]    = s_s7;
	assign sq_root_s[0]   = '0;
	assign sq_a_s[0]      = a_s7;
	assign sq_side_s[0]   = side_s7;
	assign sq_beyond_s[0] = s_s7 > 82'(r_sq_q);

	for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
		localparam int B = SqSteps - 1 - k;
		logic [83:0] trial;
		logic        take;

		assign trial = (84'(sq_root_s[k]) << (B + 1)) | (84'd1 << (2 * B));
		assign take  = 84'(sq_rem_s[k]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[k+1] <= 1'b0;
			else         sq_v_s[k+1] <= sq_v_s[k];
		end

		always_ff @(posedge clk) begin
			sq_rem_s[k+1]    <= take ? 82'(84'(sq_rem_s[k]) - trial) : sq_rem_s[k];
			sq_root_s[k+1]   <= take ? (sq_root_s[k] | (41'd1 << B)) : sq_root_s[k];
			sq_a_s[k+1]      <= sq_a_s[k];
			sq_side_s[k+1]   <= sq_side_s[k];
			sq_beyond_s[k+1] <= sq_beyond_s[k];
		end
	end

	// Stage 8: radial gap selection.
	logic        v_s8;
	logic [40:0] g_s8;
	logic [36:0] a_s8;
	logic [40:0] len;
	logic [40:0] rad;

	assign len = sq_root_s[SqSteps];
	assign rad = 41'(cyl_radius_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else         v_s8 <= sq_v_s[SqSteps];
	end

	always_ff @(posedge clk) begin
		if (sq_side_s[SqSteps]) begin
			g_s8 <= (len >= rad) ? len - rad : rad - len;
		end else if (sq_beyond_s[SqSteps] && len > rad) begin
			g_s8 <= len - rad;
		end else begin
			g_s8 <= '0;
		end
		a_s8 <= sq_a_s[SqSteps];
	end

	// Stage 9: partial products of the two squares.
	logic        v_s9;
	logic [39:0] ghh_s9;
	logic [41:0] ghl_s9, gll_s9, all_s9;
	logic [31:0] ahh_s9;
	logic [36:0] ahl_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else         v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		ghh_s9 <= g_s8[40:21] * g_s8[40:21];
		ghl_s9 <= 42'(g_s8[40:21] * g_s8[20:0]);
		gll_s9 <= g_s8[20:0] * g_s8[20:0];
		ahh_s9 <= a_s8[36:21] * a_s8[36:21];
		ahl_s9 <= 37'(a_s8[36:21] * a_s8[20:0]);
		all_s9 <= a_s8[20:0] * a_s8[20:0];
	end

	// Stage 10: exact sum with the rounding half added.
	logic        v_s10;
	logic [82:0] x_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else         v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		x_s10 <= (83'(ghh_s9) << 42) + (83'(ghl_s9) << 22) + 83'(gll_s9)
		       + (83'(ahh_s9) << 42) + (83'(ahl_s9) << 22) + 83'(all_s9)
		       + 83'd32768;
	end

	// Output register with saturation.
	logic              result_valid_q;
	cpsd_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid_q <= 1'b0;
		else         result_valid_q <= v_s10;
	end

	always_ff @(posedge clk) begin
		if (|x_s10[82:64]) begin
			result_q.sqr_distance <= '1;
			result_q.saturated    <= 1'b1;
		end else begin
			result_q.sqr_distance <= x_s10[63:16];
			result_q.saturated    <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Latency result_valid)
		else $error("accepted point produced no result at the expected cycle");

	a_sqrt_rem : assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[SqSteps] |-> (83'(sq_rem_s[SqSteps]) <= (83'(sq_root_s[SqSteps]) << 1)))
		else $error("square root remainder out of range");

	a_sat_value : assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.saturated) |-> (&result.sqr_distance))
		else $error("saturated result is not the maximum value");
`endif

endmodule
